// File: rtl/core/nested_batch_job_dispatcher_unit_assert.svh
// Assertion macros for the nested batch job dispatcher.
// Each macro is clocked on clk_i and disabled while rst_ni is low.
`ifndef NESTED_BATCH_JOB_DISPATCHER_UNIT_ASSERT_SVH
`define NESTED_BATCH_JOB_DISPATCHER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define NBJD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NBJD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define NBJD_ASSERT(label, prop, msg)
`define NBJD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/nbjd_pkg.sv
// Shared constants, request and status codes and the slot entry layout
// of the nested batch job dispatcher. No dependencies.
package nbjd_pkg;

  localparam int unsigned SlotsDefault   = 128;
  localparam int unsigned MaxJobsDefault = 1023;
  localparam int unsigned SlotFieldSpan  = 128;

  localparam int unsigned ActionW  = 3;
  localparam int unsigned SlotW    = 7;
  localparam int unsigned JobW     = 10;
  localparam int unsigned DepthW   = 7;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned NestW    = 8;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned ThreadsW = 7;
  localparam int unsigned MaxJobsW = 17;

  localparam logic [ActionW-1:0] ActOpen     = 3'd0;
  localparam logic [ActionW-1:0] ActClaimAny = 3'd1;
  localparam logic [ActionW-1:0] ActClaimOwn = 3'd2;
  localparam logic [ActionW-1:0] ActDone     = 3'd3;
  localparam logic [ActionW-1:0] ActRelease  = 3'd4;

  localparam logic [StatusW-1:0] StOk     = 3'd0;
  localparam logic [StatusW-1:0] StNone   = 3'd1;
  localparam logic [StatusW-1:0] StFull   = 3'd2;
  localparam logic [StatusW-1:0] StSingle = 3'd3;
  localparam logic [StatusW-1:0] StEmpty  = 3'd4;
  localparam logic [StatusW-1:0] StError  = 3'd5;

  typedef struct packed {
    logic [JobW-1:0]   total;
    logic [JobW-1:0]   next;
    logic [JobW-1:0]   outst;
    logic [DepthW-1:0] depth;
    logic [SeqW-1:0]   seq;
  } entry_t;

endpackage

// File: rtl/core/nested_batch_job_dispatcher_unit.sv
// Top level of the nested batch job dispatcher: request control and slot table.
// Depends on nbjd_pkg, nbjd_ram and nested_batch_job_dispatcher_unit_assert.svh.
//
// The dispatcher keeps a table of job batches, one entry per slot in a RAM with
// a registered read, plus an active bit per slot in flip-flops cleared at reset,
// so no clearing pass is needed. One request is handled at a time; the result
// sits in an output register, and the next request is taken while it waits. A
// claim-any request reads every usable slot once through the RAM read port. An
// open request scans the active bits from slot zero and takes the first free
// slot, or reports the table full when no slot is free. Claim-own, job-done
// and release requests read their own slot from the RAM once; requests
// rejected at once go straight to the finish state.
`include "nested_batch_job_dispatcher_unit_assert.svh"

module nested_batch_job_dispatcher_unit import nbjd_pkg::*; #(
  parameter int unsigned SLOTS    = SlotsDefault,
  parameter int unsigned MAX_JOBS = MaxJobsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ThreadsW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ActionW-1:0]  action_i,
  input  logic [SlotW-1:0]    slot_i,
  input  logic [JobW-1:0]     job_count_i,
  input  logic [DepthW-1:0]   caller_depth_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [SlotW-1:0]    granted_slot_o,
  output logic [JobW-1:0]     job_index_o,
  output logic [NestW-1:0]    job_nesting_o,
  output logic                batch_finished_o
);

  localparam int unsigned Usable   = (SLOTS < SlotFieldSpan) ? SLOTS : SlotFieldSpan;
  localparam int unsigned SW       = $clog2(Usable);
  localparam int unsigned EntryW   = $bits(entry_t);
  localparam int unsigned SlotCmpW = SlotW + 1;
  localparam logic [SW-1:0]       LastIdx     = SW'(Usable - 1);
  localparam logic [SlotCmpW-1:0] UsableLimit = SlotCmpW'(Usable);
  localparam logic [MaxJobsW-1:0] MaxJobsLim  = MaxJobsW'(MAX_JOBS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN_SCAN,
    S_ANY_SCAN,
    S_ANY_LAST,
    S_ANY_COMMIT,
    S_SLOT_EXEC,
    S_FINISH
  } state_e;

  state_e              state_q;
  logic [ThreadsW-1:0] pool_threads_q;
  logic                active_q [Usable];
  logic [SeqW-1:0]     seq_q;
  logic [SW-1:0]       cnt_q;

  logic [ActionW-1:0]  act_q;
  logic [SW-1:0]       slot_q;
  logic [JobW-1:0]     jobs_q;
  logic [DepthW-1:0]   depth_q;

  logic                rd_vld_q;
  logic [SW-1:0]       rd_idx_q;
  logic                rd_act_q;
  logic                found_q;
  entry_t              best_q;
  logic [SW-1:0]       best_idx_q;

  logic [StatusW-1:0]  res_status_q;
  logic [SlotW-1:0]    res_slot_q;
  logic [JobW-1:0]     res_index_q;
  logic [NestW-1:0]    res_nest_q;
  logic                res_fin_q;

  logic                out_valid_q;
  logic [StatusW-1:0]  status_q;
  logic [SlotW-1:0]    granted_slot_q;
  logic [JobW-1:0]     job_index_q;
  logic [NestW-1:0]    job_nesting_q;
  logic                batch_finished_q;

  logic [SW-1:0]       addr;
  logic                act_rd;
  logic                in_acc;
  logic                slot_ok_in;
  logic [EntryW-1:0]   ram_rdata;
  entry_t              rd_e;
  entry_t              wr_e;
  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic                take;
  logic                own_avail;
  logic [JobW-1:0]     unclaimed;
  logic                done_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign addr       = (state_q == S_IDLE) ? slot_i[SW-1:0] : cnt_q;
  assign act_rd     = active_q[addr];
  assign slot_ok_in = ({1'b0, slot_i} < UsableLimit) && act_rd;
  assign rd_e       = entry_t'(ram_rdata);

  assign take = rd_vld_q && rd_act_q && (rd_e.next < rd_e.total) &&
                (!found_q || (rd_e.depth > best_q.depth) ||
                 ((rd_e.depth == best_q.depth) && (rd_e.seq > best_q.seq)));

  assign own_avail = rd_e.next < rd_e.total;
  assign unclaimed = (rd_e.next <= rd_e.total) ? (rd_e.total - rd_e.next) : '0;
  assign done_ok   = rd_e.outst > unclaimed;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    wr_e      = rd_e;
    case (state_q)
      S_OPEN_SCAN: begin
        ram_we     = !act_rd;
        ram_waddr  = cnt_q;
        wr_e.total = jobs_q;
        wr_e.next  = '0;
        wr_e.outst = jobs_q;
        wr_e.depth = depth_q;
        wr_e.seq   = seq_q;
      end
      S_ANY_COMMIT: begin
        ram_we    = found_q;
        ram_waddr = best_idx_q;
        wr_e      = best_q;
        wr_e.next = best_q.next + JobW'(1);
      end
      S_SLOT_EXEC: begin
        if (act_q == ActClaimOwn) begin
          ram_we    = own_avail;
          wr_e.next = rd_e.next + JobW'(1);
        end else if (act_q == ActDone) begin
          ram_we     = done_ok;
          wr_e.outst = rd_e.outst - JobW'(1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  nbjd_ram #(
    .WIDTH(EntryW),
    .DEPTH(Usable)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_e),
    .raddr_i(addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      pool_threads_q   <= ThreadsW'(1);
      for (int i = 0; i < Usable; i++) begin
        active_q[i] <= 1'b0;
      end
      seq_q            <= '0;
      cnt_q            <= '0;
      act_q            <= '0;
      slot_q           <= '0;
      jobs_q           <= '0;
      depth_q          <= '0;
      rd_vld_q         <= 1'b0;
      rd_idx_q         <= '0;
      rd_act_q         <= 1'b0;
      found_q          <= 1'b0;
      best_q           <= '0;
      best_idx_q       <= '0;
      res_status_q     <= StError;
      res_slot_q       <= '0;
      res_index_q      <= '0;
      res_nest_q       <= '0;
      res_fin_q        <= 1'b0;
      out_valid_q      <= 1'b0;
      status_q         <= StError;
      granted_slot_q   <= '0;
      job_index_q      <= '0;
      job_nesting_q    <= '0;
      batch_finished_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_threads_q <= cfg_wdata_i;
      end
      if ((state_q == S_FINISH) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= (state_q == S_ANY_SCAN);

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q        <= action_i;
            slot_q       <= slot_i[SW-1:0];
            jobs_q       <= job_count_i;
            depth_q      <= caller_depth_i;
            cnt_q        <= '0;
            found_q      <= 1'b0;
            res_slot_q   <= '0;
            res_index_q  <= '0;
            res_nest_q   <= '0;
            res_fin_q    <= 1'b0;
            case (action_i)
              ActOpen: begin
                if (job_count_i == '0) begin
                  res_status_q <= StEmpty;
                  state_q      <= S_FINISH;
                end else if (MaxJobsW'(job_count_i) > MaxJobsLim) begin
                  res_status_q <= StError;
                  state_q      <= S_FINISH;
                end else if (pool_threads_q <= ThreadsW'(1)) begin
                  res_status_q <= StSingle;
                  state_q      <= S_FINISH;
                end else begin
                  state_q <= S_OPEN_SCAN;
                end
              end
              ActClaimAny: begin
                state_q <= S_ANY_SCAN;
              end
              ActClaimOwn, ActDone, ActRelease: begin
                res_status_q <= StError;
                state_q      <= slot_ok_in ? S_SLOT_EXEC : S_FINISH;
              end
              default: begin
                res_status_q <= StError;
                state_q      <= S_FINISH;
              end
            endcase
          end
        end
        S_OPEN_SCAN: begin
          if (!act_rd) begin
            active_q[cnt_q] <= 1'b1;
            seq_q           <= seq_q + SeqW'(1);
            res_status_q    <= StOk;
            res_slot_q      <= SlotW'(cnt_q);
            state_q         <= S_FINISH;
          end else if (cnt_q == LastIdx) begin
            res_status_q <= StFull;
            state_q      <= S_FINISH;
          end else begin
            cnt_q <= cnt_q + SW'(1);
          end
        end
        S_ANY_SCAN: begin
          rd_idx_q <= cnt_q;
          rd_act_q <= act_rd;
          if (cnt_q == LastIdx) begin
            state_q <= S_ANY_LAST;
          end else begin
            cnt_q <= cnt_q + SW'(1);
          end
        end
        S_ANY_LAST: begin
          state_q <= S_ANY_COMMIT;
        end
        S_ANY_COMMIT: begin
          if (found_q) begin
            res_status_q <= StOk;
            res_slot_q   <= SlotW'(best_idx_q);
            res_index_q  <= best_q.next;
            res_nest_q   <= NestW'(best_q.depth) + NestW'(1);
          end else begin
            res_status_q <= StNone;
          end
          state_q <= S_FINISH;
        end
        S_SLOT_EXEC: begin
          case (act_q)
            ActClaimOwn: begin
              if (own_avail) begin
                res_status_q <= StOk;
                res_slot_q   <= SlotW'(slot_q);
                res_index_q  <= rd_e.next;
                res_nest_q   <= NestW'(rd_e.depth) + NestW'(1);
              end else begin
                res_status_q <= StNone;
              end
            end
            ActDone: begin
              res_slot_q <= SlotW'(slot_q);
              if (done_ok) begin
                res_status_q <= StOk;
                res_fin_q    <= (rd_e.outst == JobW'(1));
              end
            end
            ActRelease: begin
              res_slot_q <= SlotW'(slot_q);
              if (rd_e.outst == '0) begin
                active_q[slot_q] <= 1'b0;
                res_status_q     <= StOk;
              end
            end
            default: begin
              res_status_q <= StError;
            end
          endcase
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            status_q         <= res_status_q;
            granted_slot_q   <= res_slot_q;
            job_index_q      <= res_index_q;
            job_nesting_q    <= res_nest_q;
            batch_finished_q <= res_fin_q;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (take) begin
        found_q    <= 1'b1;
        best_q     <= rd_e;
        best_idx_q <= rd_idx_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign granted_slot_o   = granted_slot_q;
  assign job_index_o      = job_index_q;
  assign job_nesting_o    = job_nesting_q;
  assign batch_finished_o = batch_finished_q;

  // The slot table must not change while a claim-any scan is reading it.
  `NBJD_ASSERT(a_no_write_in_scan,
    !(ram_we && (state_q == S_ANY_SCAN || state_q == S_ANY_LAST)),
    "slot RAM written during claim scan")
  `NBJD_ASSERT(a_finished_is_ok,
    !(out_valid_o && batch_finished_o) || (status_o == StOk),
    "batch finished flagged on a failed request")
  `NBJD_ASSERT_NEXT(a_accept_leaves_idle, in_valid_i && in_ready_o, !in_ready_o,
    "request accepted without leaving idle")
  `NBJD_ASSERT(a_scan_read_in_scan,
    !rd_vld_q || (state_q == S_ANY_LAST) || (state_q == S_ANY_SCAN),
    "scan read returned outside the scan")

endmodule

// File: rtl/core/nbjd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nbjd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
